// ===== rtl/utf8_stream_decoder_core_defines.svh =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_defines.svh
// assertion macros shared by the decoder checker
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_CORE_DEFINES_SVH
`define UTF8_STREAM_DECODER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define UTF8D_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define UTF8D_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/utf8d_pkg.sv =====
// ----------------------------------------------------------------------------
// utf8d_pkg
// types and constants of the UTF-8 stream decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int unsigned CodeW = 31;
	localparam int unsigned RemW  = 3;

	// lead byte thresholds
	localparam logic [7:0] LEAD2_MIN = 8'hC0;
	localparam logic [7:0] LEAD3_MIN = 8'hE0;
	localparam logic [7:0] LEAD4_MIN = 8'hF0;
	localparam logic [7:0] LEAD5_MIN = 8'hF8;
	localparam logic [7:0] LEAD6_MIN = 8'hFC;

	// payload masks
	localparam logic [7:0] MASK_CONT  = 8'h3F;
	localparam logic [7:0] MASK_LEAD2 = 8'h1F;
	localparam logic [7:0] MASK_LEAD3 = 8'h0F;
	localparam logic [7:0] MASK_LEAD4 = 8'h07;
	localparam logic [7:0] MASK_LEAD5 = 8'h03;
	localparam logic [7:0] MASK_LEAD6 = 8'h01;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       end_of_stream;
	} utf8d_in_t;

	typedef struct packed {
		logic [CodeW-1:0] code_point;
		logic             truncated;
		logic             stream_last;
	} utf8d_out_t;

	typedef struct packed {
		logic [RemW-1:0]  bytes_remaining;
		logic [CodeW-1:0] partial_code;
	} utf8d_state_t;

endpackage

// ===== rtl/utf8d_step.sv =====
// ----------------------------------------------------------------------------
// utf8d_step
// per-byte decode: next sequence state and the optional result
// ----------------------------------------------------------------------------
module utf8d_step (
	input  utf8d_pkg::utf8d_state_t state,
	input  utf8d_pkg::utf8d_in_t    item,
	output utf8d_pkg::utf8d_state_t state_next,
	output utf8d_pkg::utf8d_out_t   result,
	output logic                    result_valid
);

	logic [7:0]                   b;
	logic [utf8d_pkg::CodeW-1:0]  shifted;

	assign b       = item.data_byte;
	assign shifted = {state.partial_code[utf8d_pkg::CodeW-7:0], b[5:0]};

	// lead or continuation handling, then end-of-stream truncation
	always_comb begin
		state_next   = state;
		result       = '0;
		result_valid = 1'b0;
		if (state.bytes_remaining == '0) begin
			priority if (b < utf8d_pkg::LEAD2_MIN) begin
				result.code_point  = utf8d_pkg::CodeW'(b);
				result.stream_last = item.end_of_stream;
				result_valid       = 1'b1;
			end else if (b < utf8d_pkg::LEAD3_MIN) begin
				state_next.bytes_remaining = 3'd1;
				state_next.partial_code    = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD2);
			end else if (b < utf8d_pkg::LEAD4_MIN) begin
				state_next.bytes_remaining = 3'd2;
				state_next.partial_code    = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD3);
			end else if (b < utf8d_pkg::LEAD5_MIN) begin
				state_next.bytes_remaining = 3'd3;
				state_next.partial_code    = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD4);
			end else if (b < utf8d_pkg::LEAD6_MIN) begin
				state_next.bytes_remaining = 3'd4;
				state_next.partial_code    = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD5);
			end else begin
				state_next.bytes_remaining = 3'd5;
				state_next.partial_code    = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD6);
			end
		end else begin
			state_next.bytes_remaining = state.bytes_remaining - 3'd1;
			state_next.partial_code    = shifted;
			if (state.bytes_remaining == 3'd1) begin
				state_next.partial_code = '0;
				result.code_point       = shifted;
				result.stream_last      = item.end_of_stream;
				result_valid            = 1'b1;
			end
		end

		// stream ended inside a sequence
		if (!result_valid && item.end_of_stream) begin
			state_next   = '0;
			result       = '0;
			result.truncated   = 1'b1;
			result.stream_last = 1'b1;
			result_valid = 1'b1;
		end
	end

endmodule

// ===== rtl/utf8_stream_decoder_core.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core
// UTF-8 decoder with legacy five- and six-byte sequences; while the output is not stalled, one byte per cycle
// ----------------------------------------------------------------------------
//  channel   valid      ready      payload
//  input     byte_valid byte_ready byte_item  (data_byte, end_of_stream)
//  output    cp_valid   cp_ready   cp_item    (code_point, truncated, stream_last)
//
//  one byte per clock sustained while the output is not stalled; a byte is
//  taken into the input register and its result offered from the result register
//  the decode step between the two registers sets the rate
//  arst_n clears both valid flags and the sequence state
//  a stalled output holds the result register; the input register keeps
//  moving as long as its byte produces no result
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	output logic                  byte_ready,
	input  utf8d_pkg::utf8d_in_t  byte_item,
	output logic                  cp_valid,
	input  logic                  cp_ready,
	output utf8d_pkg::utf8d_out_t cp_item
);

	logic                    byte_valid_s1;
	utf8d_pkg::utf8d_in_t    byte_item_s1;
	logic                    cp_valid_s2;
	utf8d_pkg::utf8d_out_t   cp_item_s2;
	utf8d_pkg::utf8d_state_t state_q;

	utf8d_pkg::utf8d_state_t state_next;
	utf8d_pkg::utf8d_out_t   result;
	logic                    result_valid;
	logic                    out_free;
	logic                    s1_go;

	// decode step on the registered byte
	utf8d_step u_step (
		.state        (state_q),
		.item         (byte_item_s1),
		.state_next   (state_next),
		.result       (result),
		.result_valid (result_valid)
	);

	// flow control
	assign out_free   = !cp_valid_s2 || cp_ready;
	assign s1_go      = byte_valid_s1 && (!result_valid || out_free);
	assign byte_ready = !byte_valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			byte_valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_item_s1 <= byte_item;
		end
	end

	// sequence state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (s1_go) begin
			state_q <= state_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cp_valid_s2 <= 1'b0;
		end else if (out_free) begin
			cp_valid_s2 <= s1_go && result_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && s1_go && result_valid) begin
			cp_item_s2 <= result;
		end
	end

	assign cp_valid = cp_valid_s2;
	assign cp_item  = cp_item_s2;

endmodule

// ===== rtl/utf8d_checker.sv =====
// ----------------------------------------------------------------------------
// utf8d_checker
// port-level checks of the decoder, bound to the top level
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_core_defines.svh"

module utf8d_checker (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  byte_valid,
	input logic                  byte_ready,
	input utf8d_pkg::utf8d_in_t  byte_item,
	input logic                  cp_valid,
	input logic                  cp_ready,
	input utf8d_pkg::utf8d_out_t cp_item
);

	logic trunc_seen;
	logic out_stall;
	logic in_stall;

	// handshake conditions
	assign trunc_seen = cp_valid && cp_item.truncated;
	assign out_stall  = cp_valid && !cp_ready;
	assign in_stall   = byte_valid && !byte_ready;

	// a truncation error carries no code point
	`UTF8D_ASSERT_NOW(a_trunc_zero, trunc_seen, cp_item.code_point == '0, "truncation with cp")

	// a truncation error always closes the stream
	`UTF8D_ASSERT_NOW(a_trunc_last, trunc_seen, cp_item.stream_last, "truncation without last")

	// a stalled transaction stays offered
	`UTF8D_ASSERT_NEXT(a_out_hold, out_stall, cp_valid, "output valid dropped while stalled")

	// a stalled transaction keeps its payload
	`UTF8D_ASSERT_NEXT(a_out_stable, out_stall, $stable(cp_item), "output payload changed")

	// a waiting input transaction stays offered and unchanged
	`UTF8D_ASSERT_NEXT(a_in_hold, in_stall, byte_valid && $stable(byte_item), "input not held")

endmodule

bind utf8_stream_decoder_core utf8d_checker u_utf8d_checker (.*);

// ===== tb/utf8_stream_decoder_checker.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_checker
// watches both channels of the decoder, predicts each code point from the
// accepted bytes and compares every output transaction in order
// ----------------------------------------------------------------------------
module utf8_stream_decoder_checker (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  byte_valid,
	input  logic                  byte_ready,
	input  utf8d_pkg::utf8d_in_t  byte_item,
	input  logic                  cp_valid,
	input  logic                  cp_ready,
	input  utf8d_pkg::utf8d_out_t cp_item,
	output int unsigned           cp_pending,
	output int unsigned           mismatch_count
);

	localparam int unsigned ExpDepth = 2048;

	// predicted sequence state
	logic [utf8d_pkg::RemW-1:0]  seq_left;
	logic [utf8d_pkg::CodeW-1:0] seq_code;

	// code points still owed by the decoder, oldest first
	utf8d_pkg::utf8d_out_t cp_expected [ExpDepth];
	int unsigned           exp_wr;
	int unsigned           exp_rd;

	// advance the sequence state by one byte, return 1 when a code point is due
	function automatic bit decode_byte(input utf8d_pkg::utf8d_in_t item,
		output utf8d_pkg::utf8d_out_t res);
		logic [7:0] b;
		b = item.data_byte;
		res = '0;
		if (seq_left == '0) begin
			if (b < utf8d_pkg::LEAD2_MIN) begin
				// plain ascii or stray continuation byte, passed through
				res.code_point  = utf8d_pkg::CodeW'(b);
				res.stream_last = item.end_of_stream;
				return 1'b1;
			end else if (b < utf8d_pkg::LEAD3_MIN) begin
				seq_left = utf8d_pkg::RemW'(1);
				seq_code = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD2);
			end else if (b < utf8d_pkg::LEAD4_MIN) begin
				seq_left = utf8d_pkg::RemW'(2);
				seq_code = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD3);
			end else if (b < utf8d_pkg::LEAD5_MIN) begin
				seq_left = utf8d_pkg::RemW'(3);
				seq_code = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD4);
			end else if (b < utf8d_pkg::LEAD6_MIN) begin
				seq_left = utf8d_pkg::RemW'(4);
				seq_code = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD5);
			end else begin
				seq_left = utf8d_pkg::RemW'(5);
				seq_code = utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_LEAD6);
			end
		end else begin
			// continuation byte, tag bits ignored
			seq_code = (seq_code << 6) | utf8d_pkg::CodeW'(b & utf8d_pkg::MASK_CONT);
			seq_left = seq_left - 1'b1;
			if (seq_left == '0) begin
				res.code_point  = seq_code;
				res.stream_last = item.end_of_stream;
				seq_code = '0;
				return 1'b1;
			end
		end
		// stream ended inside a sequence
		if (item.end_of_stream) begin
			seq_left = '0;
			seq_code = '0;
			res.truncated   = 1'b1;
			res.stream_last = 1'b1;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// predict on byte transactions, compare on code point transactions
	always @(posedge clk or negedge arst_n) begin
		utf8d_pkg::utf8d_out_t predicted;
		utf8d_pkg::utf8d_out_t wanted;
		if (!arst_n) begin
			seq_left = '0;
			seq_code = '0;
			exp_wr = 0;
			exp_rd = 0;
			cp_pending = 0;
			mismatch_count = 0;
		end else begin
			if (byte_valid && byte_ready && decode_byte(byte_item, predicted)) begin
				cp_expected[exp_wr % ExpDepth] = predicted;
				exp_wr++;
			end
			if (cp_valid && cp_ready) begin
				if (exp_wr == exp_rd) begin
					if (mismatch_count < 10)
						$display("unexpected cp transaction: cp=%h trunc=%b last=%b",
							cp_item.code_point, cp_item.truncated, cp_item.stream_last);
					mismatch_count++;
				end else begin
					wanted = cp_expected[exp_rd % ExpDepth];
					exp_rd++;
					if (wanted.code_point !== cp_item.code_point ||
						wanted.truncated !== cp_item.truncated ||
						wanted.stream_last !== cp_item.stream_last) begin
						if (mismatch_count < 10)
							$display({"cp mismatch: expected cp=%h trunc=%b last=%b,",
								" got cp=%h trunc=%b last=%b"},
								wanted.code_point, wanted.truncated, wanted.stream_last,
								cp_item.code_point, cp_item.truncated, cp_item.stream_last);
						mismatch_count++;
					end
				end
			end
			cp_pending = exp_wr - exp_rd;
		end
	end

endmodule

// ===== tb/utf8_stream_decoder_core_test.sv =====
// ----------------------------------------------------------------------------
// utf8_stream_decoder_core_test
// drives byte streams into the decoder (directed edge cases, then random
// well-formed and broken sequences under three idling mixes) and reports
// the verdict from the checker's mismatch count
// ----------------------------------------------------------------------------
module utf8_stream_decoder_core_test;

	logic                  clk        = 1'b0;
	logic                  arst_n     = 1'b0;
	logic                  byte_valid = 1'b0;
	logic                  byte_ready;
	utf8d_pkg::utf8d_in_t  byte_item  = '0;
	logic                  cp_valid;
	logic                  cp_ready   = 1'b0;
	utf8d_pkg::utf8d_out_t cp_item;
	int unsigned           cp_pending;
	int unsigned           mismatch_count;

	// idle odds in percent for each side
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;

	utf8_stream_decoder_core DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.byte_valid (byte_valid),
		.byte_ready (byte_ready),
		.byte_item  (byte_item),
		.cp_valid   (cp_valid),
		.cp_ready   (cp_ready),
		.cp_item    (cp_item)
	);

	utf8_stream_decoder_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.byte_valid     (byte_valid),
		.byte_ready     (byte_ready),
		.byte_item      (byte_item),
		.cp_valid       (cp_valid),
		.cp_ready       (cp_ready),
		.cp_item        (cp_item),
		.cp_pending     (cp_pending),
		.mismatch_count (mismatch_count)
	);

	// clock
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// receiver stalls at random
	always @(posedge clk) begin
		cp_ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// one byte transaction, with a random gap in front
	task automatic push_byte(input logic [7:0] b, input logic eos);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_valid <= 1'b0;
			@(posedge clk);
		end
		byte_valid <= 1'b1;
		byte_item  <= '{data_byte: b, end_of_stream: eos};
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
	endtask

	// one random sequence: lead of any length class, mostly tagged continuations,
	// sometimes ending the stream, sometimes cut short
	task automatic send_sequence(output int unsigned count);
		int unsigned seq_len;
		int unsigned stop;
		logic [7:0]  lead;
		logic [7:0]  b;
		bit          ends;
		seq_len = $urandom_range(1, 6);
		case (seq_len)
			1: begin
				lead = 8'($urandom_range(0, utf8d_pkg::LEAD2_MIN - 1));
			end
			2: begin
				lead = 8'($urandom_range(utf8d_pkg::LEAD2_MIN, utf8d_pkg::LEAD3_MIN - 1));
			end
			3: begin
				lead = 8'($urandom_range(utf8d_pkg::LEAD3_MIN, utf8d_pkg::LEAD4_MIN - 1));
			end
			4: begin
				lead = 8'($urandom_range(utf8d_pkg::LEAD4_MIN, utf8d_pkg::LEAD5_MIN - 1));
			end
			5: begin
				lead = 8'($urandom_range(utf8d_pkg::LEAD5_MIN, utf8d_pkg::LEAD6_MIN - 1));
			end
			default: begin
				lead = 8'($urandom_range(utf8d_pkg::LEAD6_MIN, 8'hFF));
			end
		endcase
		ends = ($urandom_range(99) < 12);
		stop = seq_len - 1;
		if (ends && seq_len > 1 && $urandom_range(2) == 0)
			stop = $urandom_range(0, seq_len - 2);
		for (int i = 0; i <= stop; i++) begin
			if (i == 0)
				b = lead;
			else if ($urandom_range(9) == 0)
				b = 8'($urandom);
			else
				b = {2'b10, 6'($urandom)};
			push_byte(b, ends && (i == stop));
		end
		count = stop + 1;
	endtask

	// reset, stimulus and verdict
	initial begin
		logic [8:0]  directed [22];
		int unsigned sent;
		int unsigned n;
		// {data_byte, end_of_stream}
		directed = '{
			{8'h00, 1'b1},                                  // zero byte closing a stream
			{8'h7F, 1'b0},
			{8'h80, 1'b0},                                  // stray continuation as lead
			{8'hC0, 1'b0}, {8'h80, 1'b0},                   // smallest two-byte lead
			{8'hDF, 1'b0}, {8'h3F, 1'b0},                   // continuation without tag
			{8'hEF, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b0},
			{8'hF7, 1'b0}, {8'hBF, 1'b0}, {8'hBF, 1'b1},    // four-byte cut short
			{8'hF8, 1'b1},                                  // stream ends on a lead
			{8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},    // six-byte, all ones
			{8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b1},
			{8'hFE, 1'b1},                                  // six-byte lead, then end
			{8'hBF, 1'b1}                                   // stray byte ending a stream
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		send_idle_pct = 25;
		recv_idle_pct = 78;
		foreach (directed[i])
			push_byte(directed[i][8:1], directed[i][0]);

		// three idling mixes
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle_pct = 25;
					recv_idle_pct = 78;
				end
				1: begin
					send_idle_pct = 78;
					recv_idle_pct = 25;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			sent = 0;
			while (sent < 400) begin
				send_sequence(n);
				sent += n;
			end
		end

		// drain
		byte_valid <= 1'b0;
		@(posedge clk);
		while (cp_pending != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	// watchdog
	initial begin
		#6000000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ===== utf8_stream_decoder_core.f =====
+incdir+rtl
rtl/utf8d_pkg.sv
rtl/utf8d_step.sv
rtl/utf8_stream_decoder_core.sv
rtl/utf8d_checker.sv
tb/utf8_stream_decoder_checker.sv
tb/utf8_stream_decoder_core_test.sv
